// ===== rtl/ats_pkg.sv =====
`timescale 1ns / 1ps
// ats_pkg: shared types, tone table, sine quarter-wave and register map for
// the alert tone sequencer. No dependencies.
package ats_pkg;

  localparam int unsigned DEF_SAMPLE_RATE = 16000;
  localparam int unsigned RAMP_DIV        = 500;
  localparam int unsigned MS_PER_S        = 1000;
  localparam int unsigned PADDR_W         = 3;
  localparam int unsigned PDATA_W         = 32;
  localparam logic [15:0] AMP_HOLD_RST    = 16'd4800;
  localparam logic [7:0]  ENV_FULL        = 8'hFF;
  localparam logic [1:0]  PAT_CRITICAL    = 2'd2;

  // Tone slots: info {0}, warn {1,2}, critical {3,4,5}
  localparam int unsigned TONE_SLOTS = 6;
  localparam int unsigned TONE_HZ     [TONE_SLOTS] = '{880, 988, 988, 1319, 1568, 2093};
  localparam int unsigned TONE_ON_MS  [TONE_SLOTS] = '{150, 100, 100, 70, 70, 120};
  localparam int unsigned TONE_GAP_MS [TONE_SLOTS] = '{0, 90, 0, 60, 60, 0};
  localparam logic [2:0]  PAT_BASE    [4] = '{3'd0, 3'd1, 3'd3, 3'd0};
  localparam logic [1:0]  PAT_COUNT   [4] = '{2'd1, 2'd2, 2'd3, 2'd0};

  typedef enum logic [0:0] {
    REG_SOUND_ENABLE = 1'b0,
    REG_AMP_HOLD     = 1'b1
  } ats_reg_e;

  // Front stage to scaler
  typedef struct packed {
    logic               valid;
    logic signed [15:0] rom;
    logic [7:0]         env;
    logic               cue;
    logic               amp;
  } ats_stage_t;

  localparam logic [14:0] QUARTER [65] = '{
    15'd0, 15'd687, 15'd1373, 15'd2059, 15'd2744, 15'd3427, 15'd4108, 15'd4786,
    15'd5462, 15'd6134, 15'd6803, 15'd7467, 15'd8127, 15'd8783, 15'd9432, 15'd10077,
    15'd10715, 15'd11346, 15'd11971, 15'd12589, 15'd13199, 15'd13801, 15'd14394,
    15'd14979, 15'd15555, 15'd16122, 15'd16679, 15'd17226, 15'd17763, 15'd18288,
    15'd18803, 15'd19307, 15'd19798, 15'd20278, 15'd20746, 15'd21201, 15'd21644,
    15'd22073, 15'd22489, 15'd22892, 15'd23281, 15'd23655, 15'd24016, 15'd24362,
    15'd24693, 15'd25010, 15'd25311, 15'd25597, 15'd25868, 15'd26123, 15'd26363,
    15'd26586, 15'd26794, 15'd26985, 15'd27160, 15'd27319, 15'd27461, 15'd27587,
    15'd27696, 15'd27789, 15'd27865, 15'd27924, 15'd27966, 15'd27991, 15'd28000
  };

  function automatic int unsigned max_tone_ms();
    int unsigned m;
    m = 0;
    for (int i = 0; i < TONE_SLOTS; i++) begin
      if (TONE_ON_MS[i] + TONE_GAP_MS[i] > m) begin
        m = TONE_ON_MS[i] + TONE_GAP_MS[i];
      end
    end
    return m;
  endfunction

  function automatic logic signed [15:0] sine_rom(input logic [7:0] idx);
    logic [6:0]  j;
    logic [6:0]  k;
    logic [14:0] v;
    j = idx[6:0];
    k = 7'(8'd128 - {1'b0, j});
    v = (j <= 7'd64) ? QUARTER[j] : QUARTER[k];
    return idx[7] ? -$signed({1'b0, v}) : $signed({1'b0, v});
  endfunction

endpackage

// ===== rtl/ats_req_if.sv =====
`timescale 1ns / 1ps
// ats_req_if: request channel (notify / frame tick) of the alert tone sequencer.
// No dependencies.
interface ats_req_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] level;

  modport source (output valid, req_type, level, input ready);
  modport sink (input valid, req_type, level, output ready);
endinterface

// ===== rtl/ats_res_if.sv =====
`timescale 1ns / 1ps
// ats_res_if: sample result channel of the alert tone sequencer.
// No dependencies.
interface ats_res_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  logic               cue_active;
  logic               amp_enable;

  modport source (output valid, sample, cue_active, amp_enable, input ready);
  modport sink (input valid, sample, cue_active, amp_enable, output ready);
endinterface

// ===== rtl/alert_tone_sequencer_unit.sv =====
`timescale 1ns / 1ps
// Channel  | Dir | Payload                          | Beat
// req_i    | in  | req_type, level                  | valid & ready
// res_o    | out | sample, cue_active, amp_enable   | valid & ready
// apb      | in  | paddr, pwdata / prdata           | psel & penable & pwrite
// One beat per cycle while res_o is not stalled; a tick's sample reaches res_o
// through the sequencer register, product register and divide-by-255 output
// register. Notify beats and beats taken while sound_enable is low give no
// result. A stalled res_o freezes the whole pipe and drops req_i.ready.
// Reset: asynchronous, active low.
module alert_tone_sequencer_unit #(
  parameter int unsigned SAMPLE_RATE = ats_pkg::DEF_SAMPLE_RATE
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  ats_req_if.sink                     req_i,
  ats_res_if.source                   res_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ats_pkg::PADDR_W-1:0] paddr,
  input  logic [ats_pkg::PDATA_W-1:0] pwdata,
  output logic [ats_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);
  import ats_pkg::*;

  localparam int unsigned RAMP_RAW = SAMPLE_RATE / RAMP_DIV;
  localparam int unsigned RAMP     = (RAMP_RAW < 1) ? 1 : RAMP_RAW;
  localparam int unsigned RW       = (RAMP > 1) ? $clog2(RAMP) : 1;
  localparam int unsigned FW       = $clog2(max_tone_ms() * SAMPLE_RATE / MS_PER_S + 1);

  logic [FW-1:0] on_tab  [TONE_SLOTS];
  logic [FW-1:0] tot_tab [TONE_SLOTS];
  logic [15:0]   step_tab[TONE_SLOTS];
  logic [7:0]    env_lut [RAMP];

  for (genvar g = 0; g < TONE_SLOTS; g++) begin : g_tone
    localparam int unsigned OnF  = TONE_ON_MS[g] * SAMPLE_RATE / MS_PER_S;
    localparam int unsigned GapF = TONE_GAP_MS[g] * SAMPLE_RATE / MS_PER_S;
    localparam int unsigned Step = (TONE_HZ[g] << 16) / SAMPLE_RATE;
    assign on_tab[g]   = FW'(OnF);
    assign tot_tab[g]  = FW'(OnF + GapF);
    assign step_tab[g] = 16'(Step);
  end

  for (genvar g = 0; g < RAMP; g++) begin : g_env
    assign env_lut[g] = 8'((g * 255) / RAMP);
  end

  logic          sound_en_q, sound_en_d;
  logic [15:0]   amp_hold_q, amp_hold_d;
  logic [1:0]    pattern_q, pattern_d;
  logic [1:0]    tone_idx_q, tone_idx_d;
  logic [FW-1:0] frame_q, frame_d;
  logic [15:0]   phase_q, phase_d;
  logic          playing_q, playing_d;
  logic          amp_on_q, amp_on_d;
  logic [15:0]   hold_q, hold_d;
  ats_stage_t    a_q, a_d;

  logic          adv, accept, cfg_wr;
  logic [2:0]    slot_raw, slot;
  logic [FW-1:0] on_f, tot_f, frame_inc;
  logic [15:0]   step;
  logic [1:0]    tone_cnt, tone_next;
  logic          past_end, in_ramp_up, in_ramp_dn;
  logic [RW-1:0] env_idx;
  logic [7:0]    env;

  assign adv          = !res_o.valid || res_o.ready;
  assign req_i.ready  = adv;
  assign accept       = req_i.valid && adv;
  assign pready       = 1'b1;
  assign cfg_wr       = psel && penable && pwrite;

  // Config registers
  always_comb begin
    sound_en_d = sound_en_q;
    amp_hold_d = amp_hold_q;
    if (cfg_wr) begin
      case (ats_reg_e'(paddr[2]))
        REG_SOUND_ENABLE: sound_en_d = pwdata[0];
        REG_AMP_HOLD:     amp_hold_d = pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ats_reg_e'(paddr[2]))
      REG_SOUND_ENABLE: prdata = {{(PDATA_W-1){1'b0}}, sound_en_q};
      REG_AMP_HOLD:     prdata = {{(PDATA_W-16){1'b0}}, amp_hold_q};
      default:          prdata = '0;
    endcase
  end

  // Current tone lookup
  assign tone_cnt  = PAT_COUNT[pattern_q];
  assign slot_raw  = PAT_BASE[pattern_q] + 3'(tone_idx_q);
  assign slot      = (slot_raw < 3'(TONE_SLOTS)) ? slot_raw : 3'd0;
  assign on_f      = on_tab[slot];
  assign tot_f     = tot_tab[slot];
  assign step      = step_tab[slot];
  assign frame_inc = frame_q + FW'(1);
  assign tone_next = tone_idx_q + 2'd1;
  assign past_end  = tone_idx_q >= tone_cnt;

  assign in_ramp_up = frame_q < FW'(RAMP);
  assign in_ramp_dn = frame_q > (on_f - FW'(RAMP));
  assign env_idx    = in_ramp_up ? frame_q[RW-1:0] : RW'(on_f - frame_q);
  assign env        = (in_ramp_up || in_ramp_dn) ? env_lut[env_idx] : ENV_FULL;

  always_comb begin
    pattern_d  = pattern_q;
    tone_idx_d = tone_idx_q;
    frame_d    = frame_q;
    phase_d    = phase_q;
    playing_d  = playing_q;
    amp_on_d   = amp_on_q;
    hold_d     = hold_q;
    a_d        = '0;
    if (accept && sound_en_q) begin
      if (!req_i.req_type) begin
        pattern_d  = (req_i.level >= 8'd2) ? PAT_CRITICAL : req_i.level[1:0];
        tone_idx_d = '0;
        frame_d    = '0;
        phase_d    = '0;
        playing_d  = 1'b1;
        amp_on_d   = 1'b1;
        hold_d     = '0;
      end else begin
        a_d.valid = 1'b1;
        if (playing_q && !past_end) begin
          a_d.cue = 1'b1;
          if (frame_q < on_f) begin
            a_d.rom = sine_rom(phase_q[15:8]);
            a_d.env = env;
            phase_d = phase_q + step;
          end
          frame_d = frame_inc;
          if (frame_inc >= tot_f) begin
            frame_d    = '0;
            phase_d    = '0;
            tone_idx_d = tone_next;
            if (tone_next >= tone_cnt) begin
              playing_d = 1'b0;
              hold_d    = amp_hold_q;
            end
          end
        end else begin
          if (playing_q) begin
            playing_d = 1'b0;
          end
          if (playing_q && amp_hold_q != '0) begin
            hold_d = amp_hold_q - 16'd1;
          end else if (playing_q || (amp_on_q && hold_q == '0)) begin
            amp_on_d = 1'b0;
            hold_d   = '0;
          end else if (amp_on_q) begin
            hold_d = hold_q - 16'd1;
          end
        end
        a_d.amp = amp_on_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sound_en_q <= 1'b0;
      amp_hold_q <= AMP_HOLD_RST;
      pattern_q  <= '0;
      tone_idx_q <= '0;
      frame_q    <= '0;
      phase_q    <= '0;
      playing_q  <= 1'b0;
      amp_on_q   <= 1'b0;
      hold_q     <= '0;
      a_q        <= '0;
    end else begin
      sound_en_q <= sound_en_d;
      amp_hold_q <= amp_hold_d;
      pattern_q  <= pattern_d;
      tone_idx_q <= tone_idx_d;
      frame_q    <= frame_d;
      phase_q    <= phase_d;
      playing_q  <= playing_d;
      amp_on_q   <= amp_on_d;
      hold_q     <= hold_d;
      if (adv) begin
        a_q <= a_d;
      end
    end
  end

  ats_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .stage_i (a_q),
    .res_o   (res_o)
  );

`ifndef ASSERT_OFF
  a_cue_amp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.cue_active |-> res_o.amp_enable)
    else $error("cue without amp enable");
  a_play_amp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    playing_q |-> amp_on_q)
    else $error("playing with amp off");
  a_hold_amp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_q != '0 |-> amp_on_q)
    else $error("hold count live with amp off");
  a_stall_keep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(a_q))
    else $error("front stage moved during stall");
`endif

endmodule

// ===== rtl/ats_scale.sv =====
`timescale 1ns / 1ps
// ats_scale: envelope scaling, rom * env / 255 truncated toward zero, in two
// registered stages driving the result channel. Uses ats_pkg, ats_res_if.
module ats_scale (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  ats_pkg::ats_stage_t stage_i,
  ats_res_if.source           res_o
);
  import ats_pkg::*;

  typedef struct packed {
    logic        valid;
    logic [22:0] prod;
    logic        neg;
    logic        cue;
    logic        amp;
  } prod_t;

  prod_t b_d, b_q;

  logic [14:0] mag;
  logic [23:0] est_sum;
  logic [15:0] q_est;
  logic [23:0] rem;
  logic [15:0] quot;
  logic signed [15:0] sample_d, sample_q;
  logic valid_q, cue_q, amp_q;

  assign mag = stage_i.rom[15] ? 15'(-stage_i.rom) : stage_i.rom[14:0];

  always_comb begin
    b_d.valid = stage_i.valid;
    b_d.prod  = 23'(mag) * 23'(stage_i.env);
    b_d.neg   = stage_i.rom[15];
    b_d.cue   = stage_i.cue;
    b_d.amp   = stage_i.amp;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_q <= '0;
    end else if (adv_i) begin
      b_q <= b_d;
    end
  end

  // x/255 ~ (x + x>>8 + x>>16) >> 8, low by at most one
  assign est_sum = 24'(b_q.prod) + 24'(b_q.prod >> 8) + 24'(b_q.prod >> 16);
  assign q_est   = est_sum[23:8];
  assign rem     = 24'(b_q.prod) - ((24'(q_est) << 8) - 24'(q_est));
  assign quot    = (rem >= 24'd255) ? q_est + 16'd1 : q_est;
  assign sample_d = b_q.neg ? -$signed(quot) : $signed(quot);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= b_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      sample_q <= sample_d;
      cue_q    <= b_q.cue;
      amp_q    <= b_q.amp;
    end
  end

  assign res_o.valid      = valid_q;
  assign res_o.sample     = sample_q;
  assign res_o.cue_active = cue_q;
  assign res_o.amp_enable = amp_q;

endmodule

// ===== tb/alert_tone_sequencer_unit_tb.sv =====
`timescale 1ns / 1ps
// alert_tone_sequencer_unit_tb: self-checking bench for the alert tone sequencer.
// Drives notify/tick beats and APB writes, predicts every sample beat in-bench.
// Depends on ats_pkg, ats_req_if, ats_res_if and alert_tone_sequencer_unit.
module alert_tone_sequencer_unit_tb;

  localparam int unsigned RATE        = 16000;
  localparam int unsigned HALF_PERIOD = 4;
  localparam int unsigned SETTLE      = 8;
  localparam int unsigned LONG_STALL  = 240;
  localparam int unsigned SHORT_GOAL  = 240;
  localparam int unsigned MAX_REPORTS = 40;
  localparam longint      TIMEOUT_NS  = 10_000_000;

  localparam logic REQ_NOTIFY = 1'b0;
  localparam logic REQ_TICK   = 1'b1;

  localparam int unsigned CHIRP_LEN    [3]    = '{1, 2, 3};
  localparam int unsigned CHIRP_HZ     [3][3] = '{'{880, 0, 0}, '{988, 988, 0},
                                                  '{1319, 1568, 2093}};
  localparam int unsigned CHIRP_ON_MS  [3][3] = '{'{150, 0, 0}, '{100, 100, 0},
                                                  '{70, 70, 120}};
  localparam int unsigned CHIRP_GAP_MS [3][3] = '{'{0, 0, 0}, '{90, 0, 0},
                                                  '{60, 60, 0}};

  // quarter sine wave, 28000 full scale
  localparam int QWAVE [65] = '{
    0, 687, 1373, 2059, 2744, 3427, 4108, 4786, 5462, 6134, 6803, 7467,
    8127, 8783, 9432, 10077, 10715, 11346, 11971, 12589, 13199, 13801,
    14394, 14979, 15555, 16122, 16679, 17226, 17763, 18288, 18803, 19307,
    19798, 20278, 20746, 21201, 21644, 22073, 22489, 22892, 23281, 23655,
    24016, 24362, 24693, 25010, 25311, 25597, 25868, 26123, 26363, 26586,
    26794, 26985, 27160, 27319, 27461, 27587, 27696, 27789, 27865, 27924,
    27966, 27991, 28000
  };

  typedef struct packed {
    logic signed [15:0] pcm;
    logic               cue;
    logic               amp;
  } frame_t;

  typedef enum logic [1:0] {
    OP_TICK,
    OP_NOTIFY,
    OP_WR_EN,
    OP_WR_HOLD
  } plan_op_e;

  typedef struct packed {
    plan_op_e    op;
    logic [15:0] arg;
    logic        typed;
    logic        yields;
    frame_t      want;
  } plan_row_t;

  localparam frame_t NO_F   = '{pcm: 16'sd0, cue: 1'b0, amp: 1'b0};
  localparam frame_t IDLE_F = '{pcm: 16'sd0, cue: 1'b0, amp: 1'b0};
  localparam frame_t ONSET  = '{pcm: 16'sd0, cue: 1'b1, amp: 1'b1};

  localparam int unsigned PLAN_ROWS = 28;
  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    '{OP_TICK,    16'h0000, 1'b1, 1'b0, NO_F},
    '{OP_NOTIFY,  16'h0002, 1'b1, 1'b0, NO_F},
    '{OP_WR_HOLD, 16'h0000, 1'b0, 1'b0, NO_F},
    '{OP_WR_EN,   16'h0001, 1'b0, 1'b0, NO_F},
    '{OP_TICK,    16'h00FF, 1'b1, 1'b1, IDLE_F},
    '{OP_NOTIFY,  16'h0000, 1'b1, 1'b0, NO_F},
    '{OP_TICK,    16'h0000, 1'b1, 1'b1, ONSET},
    '{OP_TICK,    16'h005A, 1'b0, 1'b0, NO_F},
    '{OP_TICK,    16'h00A5, 1'b0, 1'b0, NO_F},
    '{OP_NOTIFY,  16'h0001, 1'b1, 1'b0, NO_F},
    '{OP_TICK,    16'h0000, 1'b1, 1'b1, ONSET},
    '{OP_TICK,    16'h00FF, 1'b0, 1'b0, NO_F},
    '{OP_NOTIFY,  16'h00FF, 1'b1, 1'b0, NO_F},
    '{OP_TICK,    16'h0000, 1'b1, 1'b1, ONSET},
    '{OP_TICK,    16'h0001, 1'b0, 1'b0, NO_F},
    '{OP_TICK,    16'h0080, 1'b0, 1'b0, NO_F},
    '{OP_NOTIFY,  16'h0003, 1'b1, 1'b0, NO_F},
    '{OP_TICK,    16'h0000, 1'b1, 1'b1, ONSET},
    '{OP_TICK,    16'h007F, 1'b0, 1'b0, NO_F},
    '{OP_WR_EN,   16'h0000, 1'b0, 1'b0, NO_F},
    '{OP_TICK,    16'h00FF, 1'b1, 1'b0, NO_F},
    '{OP_NOTIFY,  16'h0000, 1'b1, 1'b0, NO_F},
    '{OP_WR_EN,   16'h0001, 1'b0, 1'b0, NO_F},
    '{OP_TICK,    16'h0000, 1'b0, 1'b0, NO_F},
    '{OP_NOTIFY,  16'h0080, 1'b1, 1'b0, NO_F},
    '{OP_TICK,    16'h0000, 1'b1, 1'b1, ONSET},
    '{OP_TICK,    16'h0000, 1'b0, 1'b0, NO_F},
    '{OP_WR_HOLD, 16'hFFFF, 1'b0, 1'b0, NO_F}
  };

  logic clk = 1'b0;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ats_pkg::PADDR_W-1:0] paddr;
  logic [ats_pkg::PDATA_W-1:0] pwdata;
  logic [ats_pkg::PDATA_W-1:0] prdata;
  logic pready;

  ats_req_if req_bus ();
  ats_res_if res_bus ();

  alert_tone_sequencer_unit #(
    .SAMPLE_RATE(RATE)
  ) dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .req_i   (req_bus),
    .res_o   (res_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // predicted sequencer state
  logic        en_reg;
  logic [15:0] hold_reg;
  int unsigned pat_q;
  int unsigned tone_q;
  int unsigned frame_q;
  logic [15:0] phase_q;
  bit          playing_q;
  bit          amp_q;
  logic [15:0] hold_left_q;

  frame_t      pending_frames[$];
  int unsigned fail_count;
  int unsigned total_beats;
  int unsigned ignored_beats;
  int unsigned checked_frames;
  int unsigned pattern_ends;
  int unsigned amp_drops;
  int unsigned burst_left;
  bit          tx_steady;
  int unsigned hold_off_asks;
  int unsigned hold_off_seen;
  int unsigned stall_left;
  logic [15:0] rx_word;
  logic [3:0]  rx_ptr;

  task automatic report_mismatch(input string what);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, what);
  endtask

  function automatic int unsigned ms_to_frames(input int unsigned ms);
    return ms * RATE / 1000;
  endfunction

  function automatic int unsigned pattern_frames(input int unsigned lv);
    int unsigned p;
    int unsigned n;
    p = (lv >= 2) ? 2 : lv;
    n = 0;
    for (int unsigned k = 0; k < CHIRP_LEN[p]; k++) begin
      n += ms_to_frames(CHIRP_ON_MS[p][k]) + ms_to_frames(CHIRP_GAP_MS[p][k]);
    end
    return n;
  endfunction

  function automatic int wave_at(input logic [7:0] idx);
    int unsigned j;
    int v;
    j = idx[6:0];
    v = (j <= 64) ? QWAVE[j] : QWAVE[128 - j];
    return idx[7] ? -v : v;
  endfunction

  task automatic chirp_step(input logic kind, input logic [7:0] lv,
                            output bit gives, output frame_t f);
    int unsigned on_f;
    int unsigned gap_f;
    int unsigned inc;
    int unsigned ramp;
    int v;
    int env;
    int s;
    bit cue;
    gives = 1'b0;
    f = NO_F;
    s = 0;
    cue = 1'b0;
    if (!en_reg) begin
      ignored_beats++;
      return;
    end
    if (kind == REQ_NOTIFY) begin
      pat_q = (lv >= 2) ? 2 : lv;
      tone_q = 0;
      frame_q = 0;
      phase_q = '0;
      playing_q = 1'b1;
      amp_q = 1'b1;
      hold_left_q = '0;
      return;
    end
    if (playing_q && tone_q >= CHIRP_LEN[pat_q]) begin
      playing_q = 1'b0;
      hold_left_q = hold_reg;
    end
    if (playing_q) begin
      on_f = ms_to_frames(CHIRP_ON_MS[pat_q][tone_q]);
      gap_f = ms_to_frames(CHIRP_GAP_MS[pat_q][tone_q]);
      inc = (CHIRP_HZ[pat_q][tone_q] << 16) / RATE;
      ramp = RATE / 500;
      if (ramp < 1) ramp = 1;
      cue = 1'b1;
      if (frame_q < on_f) begin
        env = 255;
        v = wave_at(phase_q[15:8]);
        if (frame_q < ramp) env = frame_q * 255 / ramp;
        else if (frame_q > on_f - ramp) env = (on_f - frame_q) * 255 / ramp;
        s = (v * env) / 255;
        phase_q = phase_q + inc[15:0];
      end
      frame_q++;
      if (frame_q >= on_f + gap_f) begin
        frame_q = 0;
        phase_q = '0;
        tone_q++;
        if (tone_q >= CHIRP_LEN[pat_q]) begin
          playing_q = 1'b0;
          hold_left_q = hold_reg;
          pattern_ends++;
        end
      end
    end else if (amp_q) begin
      if (hold_left_q == 0) begin
        amp_q = 1'b0;
        amp_drops++;
      end else begin
        hold_left_q--;
      end
    end
    gives = 1'b1;
    f.pcm = s[15:0];
    f.cue = cue;
    f.amp = amp_q;
  endtask

  task automatic offer_beat(input logic kind, input logic [7:0] lv,
                            output bit gives, output frame_t f);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = tx_steady ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
        req_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 32);
    end
    req_bus.valid    <= 1'b1;
    req_bus.req_type <= kind;
    req_bus.level    <= lv;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
    burst_left--;
    total_beats++;
    chirp_step(kind, lv, gives, f);
  endtask

  task automatic send_item(input logic kind, input logic [7:0] lv);
    bit gives;
    frame_t f;
    offer_beat(kind, lv, gives, f);
    if (gives) pending_frames.push_back(f);
  endtask

  task automatic quiesce();
    req_bus.valid <= 1'b0;
    burst_left = 0;
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic apb_xfer(input logic wr, input ats_pkg::ats_reg_e r,
                          input logic [31:0] d, output logic [31:0] q);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {r, 2'b00};
    pwdata  <= d;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    q = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_reg(input ats_pkg::ats_reg_e r, input logic [31:0] d);
    logic [31:0] q;
    logic [31:0] want;
    quiesce();
    apb_xfer(1'b1, r, d, q);
    if (r == ats_pkg::REG_SOUND_ENABLE) begin
      en_reg = d[0];
      want = {31'd0, d[0]};
    end else begin
      hold_reg = d[15:0];
      want = {16'd0, d[15:0]};
    end
    apb_xfer(1'b0, r, 32'd0, q);
    if (q !== want) report_mismatch($sformatf("%s reads 0x%0h, expected 0x%0h",
                                              r.name(), q, want));
  endtask

  // full: play a whole info chirp through to the amplifier dropping
  task automatic run_session(input int unsigned sess, input bit full);
    int unsigned lv;
    int unsigned n;
    int unsigned split;
    logic [15:0] hold_v;
    if (full) begin
      hold_v = 16'($urandom_range(0, 3));
      set_reg(ats_pkg::REG_AMP_HOLD, {16'd0, hold_v});
    end else if (sess % 3 == 0) begin
      case (sess / 3)
        0: begin
          hold_v = 16'd4800;
        end
        1: begin
          hold_v = 16'hFFFF;
        end
        2: begin
          hold_v = 16'd1;
        end
        3: begin
          hold_v = 16'd0;
        end
        default: begin
          hold_v = 16'($urandom_range(0, 48));
        end
      endcase
      set_reg(ats_pkg::REG_AMP_HOLD, {16'd0, hold_v});
    end
    tx_steady = ($urandom_range(0, 4) == 0);
    if (sess == 1 || $urandom_range(0, 9) == 0) hold_off_asks++;
    if (full) lv = 0;
    else if ($urandom_range(0, 4) == 0) lv = $urandom_range(0, 255);
    else lv = $urandom_range(0, 2);
    if (full || $urandom_range(0, 7) != 0) send_item(REQ_NOTIFY, 8'(lv));
    if (full) begin
      n = pattern_frames(lv) + 32'(hold_reg) + $urandom_range(2, 8);
    end else begin
      n = $urandom_range(1, 100);
    end
    split = (!full && $urandom_range(0, 5) == 0) ? $urandom_range(1, n) : 0;
    for (int unsigned k = 0; k < n; k++) begin
      // freeze mid-pattern, poke it while disabled, then resume
      if (split != 0 && k == split) begin
        set_reg(ats_pkg::REG_SOUND_ENABLE, 32'd0);
        repeat ($urandom_range(2, 12)) send_item(1'($urandom_range(0, 1)), 8'($urandom));
        set_reg(ats_pkg::REG_SOUND_ENABLE, 32'd1);
      end
      if (!full && $urandom_range(0, 199) == 0) send_item(REQ_NOTIFY, 8'($urandom));
      send_item(REQ_TICK, 8'($urandom));
    end
  endtask

  always @(posedge clk) begin : sample_sink
    frame_t want;
    logic nxt;
    if (rst_n && res_bus.valid && res_bus.ready) begin
      if (pending_frames.size() == 0) begin
        report_mismatch("sample beat with nothing pending");
      end else begin
        want = pending_frames.pop_front();
        checked_frames++;
        if (res_bus.sample !== want.pcm)
          report_mismatch($sformatf("beat %0d: sample %0d, expected %0d",
                                    checked_frames, res_bus.sample, want.pcm));
        if (res_bus.cue_active !== want.cue)
          report_mismatch($sformatf("beat %0d: cue_active %0b, expected %0b",
                                    checked_frames, res_bus.cue_active, want.cue));
        if (res_bus.amp_enable !== want.amp)
          report_mismatch($sformatf("beat %0d: amp_enable %0b, expected %0b",
                                    checked_frames, res_bus.amp_enable, want.amp));
      end
    end
    if (hold_off_asks != hold_off_seen) begin
      hold_off_seen = hold_off_asks;
      stall_left = LONG_STALL;
    end
    if (stall_left != 0) begin
      stall_left--;
      nxt = 1'b0;
    end else begin
      if (rx_ptr == 0) rx_word = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom | $urandom);
      nxt = rx_word[rx_ptr];
      rx_ptr++;
    end
    res_bus.ready <= nxt;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("** alert_tone_sequencer_unit: FAILED **");
    $finish;
  end

  initial begin : stimulus
    bit gives;
    frame_t f;
    int unsigned sess;
    rst_n            <= 1'b0;
    req_bus.valid    <= 1'b0;
    req_bus.req_type <= REQ_NOTIFY;
    req_bus.level    <= 8'd0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    en_reg = 1'b0;
    hold_reg = ats_pkg::AMP_HOLD_RST;
    pat_q = 0;
    tone_q = 0;
    frame_q = 0;
    phase_q = '0;
    playing_q = 1'b0;
    amp_q = 1'b0;
    hold_left_q = '0;
    fail_count = 0;
    total_beats = 0;
    ignored_beats = 0;
    checked_frames = 0;
    pattern_ends = 0;
    amp_drops = 0;
    burst_left = 0;
    tx_steady = 1'b0;
    hold_off_asks = 0;
    hold_off_seen = 0;
    stall_left = 0;
    rx_word = 16'hFFFF;
    rx_ptr = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int unsigned i = 0; i < PLAN_ROWS; i++) begin
      case (PLAN[i].op)
        OP_WR_EN: begin
          set_reg(ats_pkg::REG_SOUND_ENABLE, {16'd0, PLAN[i].arg});
        end
        OP_WR_HOLD: begin
          set_reg(ats_pkg::REG_AMP_HOLD, {16'd0, PLAN[i].arg});
        end
        default: begin
          offer_beat((PLAN[i].op == OP_TICK) ? REQ_TICK : REQ_NOTIFY, PLAN[i].arg[7:0],
                     gives, f);
          if (PLAN[i].typed) begin
            gives = PLAN[i].yields;
            f = PLAN[i].want;
          end
          if (gives) pending_frames.push_back(f);
        end
      endcase
    end

    sess = 0;
    while (total_beats < SHORT_GOAL) begin
      run_session(sess, 1'b0);
      sess++;
    end
    run_session(sess, 1'b1);
    quiesce();

    $display("Run covered %0d request beats (%0d ignored while disabled), %0d sample beats checked.",
             total_beats, ignored_beats, checked_frames);
    $display("%0d chirp patterns played out, %0d amplifier drops, %0d long output stalls.",
             pattern_ends, amp_drops, hold_off_asks);
    if (fail_count == 0) begin
      $display("** alert_tone_sequencer_unit: PASSED **");
    end else begin
      $display("** alert_tone_sequencer_unit: FAILED **");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/ats_pkg.sv
rtl/ats_req_if.sv
rtl/ats_res_if.sv
rtl/ats_scale.sv
rtl/alert_tone_sequencer_unit.sv
tb/alert_tone_sequencer_unit_tb.sv
